>>> rtl/core/rpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader percentile rank: shared package
// Field widths, default sizes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int unsigned MAX_USERS_DEF = 1024;
  localparam int unsigned MAX_PAGES_DEF = 1024;

  localparam int unsigned ID_W      = 10;
  localparam int unsigned PAGE_W    = 10;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned QW        = FRAC_BITS + 1;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic rd_user;
    logic rd_old;
    logic wr_dec;
    logic rd_new;
    logic wr_inc;
    logic res_zero;
    logic res_one;
    logic sum_init;
    logic sum_run;
    logic div_init;
    logic div_run;
    logic out_load;
  } rpr_cmd_t;

  typedef struct packed {
    logic is_query;
    logic uid_ok;
    logic page_ok;
    logic known;
    logic one_user;
    logic sum_done;
    logic div_done;
    logic out_busy;
    logic clr_last;
  } rpr_status_t;

endpackage
`default_nettype wire

>>> rtl/core/rpr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader percentile rank: datapath
// User table, page histogram with per-block sums, scan accumulator,
// serial divider and the output register.
// ----------------------------------------------------------------------------
module rpr_datapath
  import rpr_pkg::*;
#(
  parameter int unsigned MAX_USERS = MAX_USERS_DEF,
  parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpr_cmd_t          cmd_i,
  output rpr_status_t            status_o,
  input  wire logic              mode_i,
  input  wire logic [ID_W-1:0]   user_id_i,
  input  wire logic [PAGE_W-1:0] reached_page_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [QW-1:0]          cheer_fraction_o
);

  localparam int unsigned UW    = $clog2(MAX_USERS);
  localparam int unsigned PW    = $clog2(MAX_PAGES);
  localparam int unsigned SHIFT = (PW + 1) / 2;
  localparam int unsigned BLK   = 1 << SHIFT;
  localparam int unsigned NB    = (MAX_PAGES + BLK - 1) / BLK;
  localparam int unsigned BW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned BW1   = $clog2(NB + 1);
  localparam int unsigned OW1   = SHIFT + 1;
  localparam int unsigned CW    = $clog2(MAX_USERS + 1);
  localparam int unsigned CLR_N = (MAX_USERS > MAX_PAGES) ? MAX_USERS : MAX_PAGES;
  localparam int unsigned CLRW  = $clog2(CLR_N);
  localparam int unsigned DCW   = $clog2(FRAC_BITS + 1);

  // Item registers.
  logic              mode_q;
  logic [ID_W-1:0]   uid_q;
  logic [PAGE_W-1:0] page_q;

  // Memories. A user entry holds the known flag above the page.
  logic [PW:0]   umem [MAX_USERS];
  logic [CW-1:0] hmem [MAX_PAGES];
  logic [CW-1:0] bmem [NB];
  logic [PW:0]   umem_q;
  logic [CW-1:0] hist_q;
  logic [CW-1:0] blk_q;

  logic          u_we, u_re;
  logic [UW-1:0] u_wa, u_ra;
  logic [PW:0]   u_wd;
  logic          h_we, h_re;
  logic [PW-1:0] h_wa, h_ra;
  logic [CW-1:0] h_wd;
  logic          b_we, b_re;
  logic [BW-1:0] b_wa, b_ra;
  logic [CW-1:0] b_wd;

  logic [CLRW-1:0] clr_q;
  logic [CW-1:0]   active_q;

  logic [BW1-1:0] bi_q, nb_lim_q;
  logic [OW1-1:0] ki_q, off_lim_q;
  logic           bv_q, hv_q;
  logic [CW-1:0]  acc_q;

  logic [CW-1:0]  rem_q;
  logic [QW-1:0]  quo_q;
  logic [DCW-1:0] dcnt_q;
  logic [CW-1:0]  divisor;
  logic [CW:0]    rem2;
  logic           rem_ge;

  logic          out_valid_q;
  logic [QW-1:0] out_data_q;

  logic [PW-1:0] old_pg, new_pg;
  logic          uid_ok, page_ok, blk_more, bin_more;

  assign old_pg   = umem_q[PW-1:0];
  assign new_pg   = PW'(page_q);
  assign uid_ok   = 32'(uid_q) < MAX_USERS;
  assign page_ok  = 32'(page_q) < MAX_PAGES;
  assign blk_more = bi_q < nb_lim_q;
  assign bin_more = ki_q < off_lim_q;
  assign divisor  = CW'(active_q - 1'b1);
  assign rem2     = {rem_q, 1'b0};
  assign rem_ge   = rem2 >= {1'b0, divisor};

  always_comb begin
    u_we = 1'b0;
    u_wa = UW'(uid_q);
    u_wd = {1'b1, new_pg};
    u_re = cmd_i.rd_user && uid_ok;
    u_ra = UW'(uid_q);
    h_we = 1'b0;
    h_wa = new_pg;
    h_wd = CW'(hist_q + 1'b1);
    h_re = 1'b0;
    h_ra = new_pg;
    b_we = 1'b0;
    b_wa = BW'(new_pg >> SHIFT);
    b_wd = CW'(blk_q + 1'b1);
    b_re = 1'b0;
    b_ra = BW'(new_pg >> SHIFT);
    if (cmd_i.clr_en) begin
      u_we = 32'(clr_q) < MAX_USERS;
      u_wa = UW'(clr_q);
      u_wd = '0;
      h_we = 32'(clr_q) < MAX_PAGES;
      h_wa = PW'(clr_q);
      h_wd = '0;
      b_we = 32'(clr_q) < NB;
      b_wa = BW'(clr_q);
      b_wd = '0;
    end else if (cmd_i.wr_dec) begin
      // An empty bin is left at zero, and its block sum with it.
      h_we = hist_q != '0;
      h_wa = old_pg;
      h_wd = CW'(hist_q - 1'b1);
      b_we = hist_q != '0;
      b_wa = BW'(old_pg >> SHIFT);
      b_wd = CW'(blk_q - 1'b1);
    end else if (cmd_i.wr_inc) begin
      u_we = 1'b1;
      h_we = 1'b1;
      b_we = 1'b1;
    end
    if (cmd_i.rd_old) begin
      h_re = 1'b1;
      h_ra = old_pg;
      b_re = 1'b1;
      b_ra = BW'(old_pg >> SHIFT);
    end else if (cmd_i.rd_new) begin
      h_re = 1'b1;
      b_re = 1'b1;
    end else if (cmd_i.sum_run) begin
      h_re = bin_more;
      h_ra = PW'((32'(nb_lim_q) << SHIFT) + 32'(ki_q));
      b_re = blk_more;
      b_ra = BW'(bi_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_we) begin
      umem[u_wa] <= u_wd;
    end
    if (u_re) begin
      umem_q <= umem[u_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    if (h_re) begin
      hist_q <= hmem[h_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    if (b_re) begin
      blk_q <= bmem[b_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      uid_q  <= user_id_i;
      page_q <= reached_page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      active_q <= '0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= CLRW'(clr_q + 1'b1);
      end
      if (cmd_i.wr_inc && !umem_q[PW]) begin
        active_q <= CW'(active_q + 1'b1);
      end
    end
  end

  // Scan: whole blocks below the page from the block sums, and the bins of
  // the page's own block from the histogram, both in the same cycles.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_init) begin
      nb_lim_q  <= BW1'(old_pg >> SHIFT);
      off_lim_q <= OW1'(old_pg[SHIFT-1:0]);
      acc_q     <= '0;
    end else if (cmd_i.sum_run) begin
      acc_q <= CW'(acc_q + (bv_q ? blk_q : '0) + (hv_q ? hist_q : '0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bi_q <= '0;
      ki_q <= '0;
      bv_q <= 1'b0;
      hv_q <= 1'b0;
    end else if (cmd_i.sum_init) begin
      bi_q <= '0;
      ki_q <= '0;
      bv_q <= 1'b0;
      hv_q <= 1'b0;
    end else if (cmd_i.sum_run) begin
      bv_q <= blk_more;
      hv_q <= bin_more;
      if (blk_more) begin
        bi_q <= BW1'(bi_q + 1'b1);
      end
      if (bin_more) begin
        ki_q <= OW1'(ki_q + 1'b1);
      end
    end
  end

  // Restoring division. The count never exceeds the divisor, so the integer
  // bit is settled first and the fraction takes one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      quo_q <= '0;
    end else if (cmd_i.res_one) begin
      quo_q <= QW'(1) << FRAC_BITS;
    end else if (cmd_i.div_init) begin
      quo_q <= {acc_q >= divisor, {FRAC_BITS{1'b0}}};
      rem_q <= (acc_q >= divisor) ? CW'(acc_q - divisor) : acc_q;
    end else if (cmd_i.div_run) begin
      quo_q <= {quo_q[QW-1], quo_q[FRAC_BITS-2:0], rem_ge};
      rem_q <= rem_ge ? CW'(rem2 - {1'b0, divisor}) : CW'(rem2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_init) begin
      dcnt_q <= DCW'(FRAC_BITS);
    end else if (cmd_i.div_run) begin
      dcnt_q <= DCW'(dcnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= quo_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cheer_fraction_o = out_data_q;

  assign status_o.is_query = mode_q == MODE_QUERY;
  assign status_o.uid_ok   = uid_ok;
  assign status_o.page_ok  = page_ok;
  assign status_o.known    = umem_q[PW];
  assign status_o.one_user = active_q <= CW'(1);
  assign status_o.sum_done = !blk_more && !bin_more && !bv_q && !hv_q;
  assign status_o.div_done = dcnt_q == '0;
  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign status_o.clr_last = 32'(clr_q) == CLR_N - 1;

endmodule
`default_nettype wire

>>> rtl/core/rpr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader percentile rank: controller
// Sequences the clearing pass, updates and queries over the datapath.
// ----------------------------------------------------------------------------
module rpr_ctrl
  import rpr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output rpr_cmd_t         cmd_o,
  input  wire rpr_status_t status_i
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDU  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_RDN  = 4'd5;
  localparam logic [3:0] S_INC  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RDU;
        end
      end
      S_RDU: begin
        cmd_o.rd_user = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        if (status_i.is_query) begin
          if (!status_i.uid_ok || !status_i.known) begin
            cmd_o.res_zero = 1'b1;
            state_d        = S_OUT;
          end else if (status_i.one_user) begin
            cmd_o.res_one = 1'b1;
            state_d       = S_OUT;
          end else begin
            cmd_o.sum_init = 1'b1;
            state_d        = S_SUM;
          end
        end else if (!status_i.uid_ok || !status_i.page_ok) begin
          state_d = S_IDLE;
        end else if (status_i.known) begin
          cmd_o.rd_old = 1'b1;
          state_d      = S_DEC;
        end else begin
          state_d = S_RDN;
        end
      end
      S_DEC: begin
        cmd_o.wr_dec = 1'b1;
        state_d      = S_RDN;
      end
      S_RDN: begin
        cmd_o.rd_new = 1'b1;
        state_d      = S_INC;
      end
      S_INC: begin
        cmd_o.wr_inc = 1'b1;
        state_d      = S_IDLE;
      end
      S_SUM: begin
        if (status_i.sum_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          cmd_o.sum_run = 1'b1;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

`ifndef NO_ASSERTIONS
  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_en, cmd_o.wr_dec, cmd_o.wr_inc}))
    else $error("more than one memory write source active");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("result loaded over a stalled beat");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_run |-> !status_i.div_done)
    else $error("divider stepped past its last bit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_RDU))
    else $error("accepted beat did not start processing");
`endif

endmodule
`default_nettype wire

>>> rtl/core/reader_percentile_rank_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader percentile rank: top level
// Keeps each user's page and a histogram of users per page, and answers
// queries with the share of other users on a strictly lower page (Q1.16).
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one beat (mode, user_id, reached_page) whenever
//   in_valid_i is high and in_stall_o is low. An update beat yields no result;
//   a query beat yields one cheer_fraction beat on the output channel.
//   An update of a known user passes through the states read user, check,
//   decrement, read new bin and increment before the next beat is taken; an
//   update that adds a new user skips the decrement. A query on a known user
//   among several scans the histogram, reading one block sum and one bin per
//   cycle for the blocks below the page's block (B = 2**ceil(log2(MAX_PAGES)/2)
//   pages each, 32 by default) and the lower bins of its own block, then the
//   serial divider produces one fraction bit per cycle. A query on an unknown
//   user or with a single known user goes straight to the output step.
//   After reset a clearing pass over max(MAX_USERS, MAX_PAGES) addresses (1024
//   by default) zeroes the tables; in_stall_o stays high meanwhile.
//   The result waits in an output register while out_stall_i is high; the
//   block keeps accepting beats, but a later query waits in its output step,
//   with in_stall_o high, until that register is free.
// ----------------------------------------------------------------------------
module reader_percentile_rank_top
  import rpr_pkg::*;
#(
  parameter int unsigned MAX_USERS = MAX_USERS_DEF,
  parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic [ID_W-1:0]   user_id_i,
  input  wire logic [PAGE_W-1:0] reached_page_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [QW-1:0]          cheer_fraction_o
);

  rpr_cmd_t    cmd;
  rpr_status_t status;

  rpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  rpr_datapath #(
    .MAX_USERS (MAX_USERS),
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (mode_i),
    .user_id_i        (user_id_i),
    .reached_page_i   (reached_page_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cheer_fraction_o (cheer_fraction_o)
  );

endmodule
`default_nettype wire
